[hw/rtl/mvna_pkg.sv]
`timescale 1ns / 1ps

package mvna_pkg;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FACE = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam int POS_W = 16;
    localparam int SUM_W = 48;
    localparam int FN_W  = 35;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_RD,
        ST_MUL,
        ST_SUB,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_NRM_LOAD,
        ST_NRM_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [FN_W-1:0]  d
    );
        logic signed [SUM_W:0] t;
        t = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-FN_W){d[FN_W-1]}}, d});
        if (!t[SUM_W] && t[SUM_W-1])
        begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end
        else if (t[SUM_W] && !t[SUM_W-1])
        begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end
        return t[SUM_W-1:0];
    endfunction

endpackage

[hw/rtl/mesh_vertex_normal_accumulator_unit.sv]
`timescale 1ns / 1ps

// Keeps a position and a saturating area-weighted normal sum for each vertex in two
// single-port-read memories. A face beat does three position reads, a multiply and a
// subtract step for the cross product, then a read and a write-back of the sum for each
// corner in turn. A read beat runs the iterative normalizing shift, the 32-step square
// root and three 15-step restoring divisions, while a read of a zero sum skips them;
// its result sits in an output register, and a further beat is taken once the
// result has been moved into that register. Reading a vertex that was never loaded
// returns an arbitrary normal.
module mesh_vertex_normal_accumulator_unit
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [11:0]        vertex_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [11:0]        corner_a,
    input  logic [11:0]        corner_b,
    input  logic [11:0]        corner_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        out_index,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic               degenerate
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [16:0] VMAX = 17'(MAX_VERTICES);

    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [4:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;

    logic [AW-1:0] corner_reg [3];
    logic [AW-1:0] corner_next [3];
    logic [3*POS_W-1:0] pos_reg [3];
    logic [3*POS_W-1:0] pos_next [3];
    logic signed [33:0] prod_reg [6];
    logic signed [33:0] prod_next [6];
    logic signed [FN_W-1:0] fn_reg [3];
    logic signed [FN_W-1:0] fn_next [3];
    logic [11:0] idx_reg, idx_next;
    logic [SUM_W-1:0] mag_reg [3];
    logic [SUM_W-1:0] mag_next [3];
    logic [2:0] neg_reg, neg_next;
    logic [SUM_W-1:0] m_reg, m_next;
    logic [61:0] acc_reg, acc_next;
    logic [62:0] sqn_reg, sqn_next;
    logic [62:0] res_reg, res_next;
    logic [62:0] root_bit_reg, root_bit_next;
    logic [45:0] rem_reg, rem_next;
    logic [45:0] dsh_reg, dsh_next;
    logic [14:0] q_reg, q_next;
    logic signed [15:0] norm_reg [3];
    logic signed [15:0] norm_next [3];
    logic deg_reg, deg_next;
    logic [11:0] out_index_reg, out_index_next;
    logic signed [15:0] norm_x_reg, norm_x_next;
    logic signed [15:0] norm_y_reg, norm_y_next;
    logic signed [15:0] norm_z_reg, norm_z_next;
    logic degenerate_reg, degenerate_next;

    logic pos_wr_en;
    logic [AW-1:0] pos_wr_addr, pos_rd_addr;
    logic [3*POS_W-1:0] pos_wr_data, pos_rd_data;
    logic sum_wr_en;
    logic [AW-1:0] sum_wr_addr, sum_rd_addr;
    logic [3*SUM_W-1:0] sum_wr_data, sum_rd_data;

    logic accept;
    logic vi_ok, face_ok;
    logic signed [16:0] d1 [3];
    logic signed [16:0] d2 [3];
    logic signed [SUM_W-1:0] s_comp [3];
    logic [59:0] sq_prod;
    logic [62:0] root_try;
    logic div_ge;
    logic [14:0] q_full;

    mvna_ram #(
        .WIDTH(3 * POS_W),
        .DEPTH(MAX_VERTICES)
    ) u_pos_ram (
        .clk(clk),
        .wr_en(pos_wr_en),
        .wr_addr(pos_wr_addr),
        .wr_data(pos_wr_data),
        .rd_addr(pos_rd_addr),
        .rd_data(pos_rd_data)
    );

    mvna_ram #(
        .WIDTH(3 * SUM_W),
        .DEPTH(MAX_VERTICES)
    ) u_sum_ram (
        .clk(clk),
        .wr_en(sum_wr_en),
        .wr_addr(sum_wr_addr),
        .wr_data(sum_wr_data),
        .rd_addr(sum_rd_addr),
        .rd_data(sum_rd_data)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign norm_x     = norm_x_reg;
    assign norm_y     = norm_y_reg;
    assign norm_z     = norm_z_reg;
    assign degenerate = degenerate_reg;

    assign vi_ok   = {5'd0, vertex_index} < VMAX;
    assign face_ok = ({5'd0, corner_a} < VMAX) && ({5'd0, corner_b} < VMAX)
                     && ({5'd0, corner_c} < VMAX);

    assign pos_wr_addr = AW'(vertex_index);
    assign pos_wr_data = {pos_z, pos_y, pos_x};
    assign pos_rd_addr = (cnt_reg == 2'd3) ? '0 : corner_reg[cnt_reg];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = $signed({pos_reg[1][16*k+15], pos_reg[1][16*k +: 16]})
                    - $signed({pos_reg[0][16*k+15], pos_reg[0][16*k +: 16]});
            d2[k] = $signed({pos_reg[2][16*k+15], pos_reg[2][16*k +: 16]})
                    - $signed({pos_reg[0][16*k+15], pos_reg[0][16*k +: 16]});
            s_comp[k] = $signed(sum_rd_data[SUM_W*k +: SUM_W]);
        end
    end

    assign sq_prod  = mag_reg[cnt_reg == 2'd3 ? 2'd0 : cnt_reg][29:0]
                      * mag_reg[cnt_reg == 2'd3 ? 2'd0 : cnt_reg][29:0];
    assign root_try = res_reg + root_bit_reg;
    assign div_ge   = rem_reg >= dsh_reg;
    assign q_full   = {q_reg[13:0], div_ge};

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        corner_next     = corner_reg;
        pos_next        = pos_reg;
        prod_next       = prod_reg;
        fn_next         = fn_reg;
        idx_next        = idx_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        m_next          = m_reg;
        acc_next        = acc_reg;
        sqn_next        = sqn_reg;
        res_next        = res_reg;
        root_bit_next   = root_bit_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        norm_next       = norm_reg;
        deg_next        = deg_reg;
        out_index_next  = out_index_reg;
        norm_x_next     = norm_x_reg;
        norm_y_next     = norm_y_reg;
        norm_z_next     = norm_z_reg;
        degenerate_next = degenerate_reg;
        pos_wr_en       = 1'b0;
        sum_wr_en       = 1'b0;
        sum_wr_addr     = AW'(vertex_index);
        sum_wr_data     = '0;
        sum_rd_addr     = (cnt_reg == 2'd3) ? '0 : corner_reg[cnt_reg];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                sum_rd_addr = AW'(vertex_index);
                if (accept)
                begin
                    idx_next       = vertex_index;
                    corner_next[0] = AW'(corner_a);
                    corner_next[1] = AW'(corner_b);
                    corner_next[2] = AW'(corner_c);
                    cnt_next       = 2'd0;
                    case (mode)
                        MODE_LOAD:
                        begin
                            pos_wr_en = vi_ok;
                            sum_wr_en = vi_ok;
                        end
                        MODE_FACE:
                        begin
                            if (face_ok)
                            begin
                                state_next = ST_POS_RD;
                            end
                        end
                        MODE_READ:
                        begin
                            if (vi_ok)
                            begin
                                state_next = ST_NRM_LOAD;
                            end
                            else
                            begin
                                norm_next[0] = '0;
                                norm_next[1] = '0;
                                norm_next[2] = '0;
                                deg_next     = 1'b1;
                                state_next   = ST_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POS_RD:
            begin
                if (cnt_reg != 2'd0)
                begin
                    pos_next[cnt_reg - 2'd1] = pos_rd_data;
                end
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_MUL:
            begin
                prod_next[0] = d1[1] * d2[2];
                prod_next[1] = d1[2] * d2[1];
                prod_next[2] = d1[2] * d2[0];
                prod_next[3] = d1[0] * d2[2];
                prod_next[4] = d1[0] * d2[1];
                prod_next[5] = d1[1] * d2[0];
                state_next   = ST_SUB;
            end
            ST_SUB:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    fn_next[k] = $signed({prod_reg[2*k][33], prod_reg[2*k]})
                                 - $signed({prod_reg[2*k+1][33], prod_reg[2*k+1]});
                end
                cnt_next   = 2'd0;
                state_next = ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                sum_wr_en   = 1'b1;
                sum_wr_addr = (cnt_reg == 2'd3) ? '0 : corner_reg[cnt_reg];
                sum_wr_data = {sat_add(s_comp[2], fn_reg[2]),
                               sat_add(s_comp[1], fn_reg[1]),
                               sat_add(s_comp[0], fn_reg[0])};
                if (cnt_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = ST_ACC_RD;
                end
            end
            ST_NRM_LOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_next[k] = s_comp[k][SUM_W-1];
                    mag_next[k] = s_comp[k][SUM_W-1] ? (~s_comp[k] + 1'b1) : s_comp[k];
                end
                m_next = mag_next[0];
                if (mag_next[1] > m_next)
                begin
                    m_next = mag_next[1];
                end
                if (mag_next[2] > m_next)
                begin
                    m_next = mag_next[2];
                end
                if (m_next == '0)
                begin
                    norm_next[0] = '0;
                    norm_next[1] = '0;
                    norm_next[2] = '0;
                    deg_next     = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    deg_next   = 1'b0;
                    state_next = ST_NRM_SHIFT;
                end
            end
            ST_NRM_SHIFT:
            begin
                if (m_reg[SUM_W-1:30] != '0)
                begin
                    m_next = m_reg >> 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_next[k] = mag_reg[k] >> 1;
                    end
                end
                else
                begin
                    acc_next   = '0;
                    cnt_next   = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                acc_next = acc_reg + 62'(sq_prod);
                if (cnt_reg == 2'd2)
                begin
                    sqn_next      = 63'(acc_next);
                    res_next      = '0;
                    root_bit_next = 63'(1) << 62;
                    step_next     = '0;
                    state_next    = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                if (sqn_reg >= root_try)
                begin
                    sqn_next = sqn_reg - root_try;
                    res_next = (res_reg >> 1) + root_bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                root_bit_next = root_bit_reg >> 2;
                step_next     = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    cnt_next   = 2'd0;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                rem_next   = (46'(mag_reg[cnt_reg == 2'd3 ? 2'd0 : cnt_reg][29:0]) << 15)
                             + 46'(res_reg[31:0]);
                dsh_next   = 46'(res_reg[31:0]) << 15;
                q_next     = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                q_next    = q_full;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd14)
                begin
                    norm_next[cnt_reg == 2'd3 ? 2'd0 : cnt_reg] =
                        neg_reg[cnt_reg == 2'd3 ? 2'd0 : cnt_reg]
                        ? -$signed({1'b0, q_full}) : $signed({1'b0, q_full});
                    if (cnt_reg == 2'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = ST_DIV_INIT;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = idx_reg;
                    norm_x_next     = norm_reg[0];
                    norm_y_next     = norm_reg[1];
                    norm_z_next     = norm_reg[2];
                    degenerate_next = deg_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg     <= corner_next;
        pos_reg        <= pos_next;
        prod_reg       <= prod_next;
        fn_reg         <= fn_next;
        idx_reg        <= idx_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        m_reg          <= m_next;
        acc_reg        <= acc_next;
        sqn_reg        <= sqn_next;
        res_reg        <= res_next;
        root_bit_reg   <= root_bit_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        q_reg          <= q_next;
        norm_reg       <= norm_next;
        deg_reg        <= deg_next;
        out_index_reg  <= out_index_next;
        norm_x_reg     <= norm_x_next;
        norm_y_reg     <= norm_y_next;
        norm_z_reg     <= norm_z_next;
        degenerate_reg <= degenerate_next;
    end

    a_root_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> $onehot(root_bit_reg))
        else $error("square root bit is not one-hot");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("division remainder out of range");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside the done state");

endmodule

[hw/rtl/mvna_ram.sv]
`timescale 1ns / 1ps

module mvna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
